// ===== hdl/gsip_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsip_pkg: shared types and constants for the gamma spinor inner product
// Stage tag, direction type, gamma sign table and accumulator indices.
// ----------------------------------------------------------------------------
package gsip_pkg;

  typedef logic [1:0] dir_t;

  typedef struct packed {
    logic valid;
    logic last;
  } tag_t;

  // sign pair bits: set means the term is subtracted
  localparam int SIGN_A = 0;
  localparam int SIGN_B = 1;

  localparam logic [1:0] SIGN_TAB [4][2] = '{
    '{2'd0, 2'd0},
    '{2'd2, 2'd2},
    '{2'd0, 2'd3},
    '{2'd2, 2'd1}
  };

  localparam int NUM_SUMS     = 4;
  localparam int SUM_PLAIN_RE = 0;
  localparam int SUM_PLAIN_IM = 1;
  localparam int SUM_CROSS_RE = 2;
  localparam int SUM_CROSS_IM = 3;

  function automatic logic [1:0] sign_pair(input dir_t dir, input logic sel);
    return SIGN_TAB[dir][sel];
  endfunction

endpackage

// ===== hdl/gamma_spinor_inner_product.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamma_spinor_inner_product: streaming plain and gamma inner products
// The last item passes the product, contribution, hold and result registers.
// Throughput: one request per cycle unless out_ready stalls; the accumulators close
// a registered saturating add loop, products and term sums are registered ahead
// of it. Reset clears the sums, the clip flag, all stage valids and direction.
// ----------------------------------------------------------------------------
module gamma_spinor_inner_product #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH = 52
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [1:0]                    direction,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          pair_select,
  input  logic signed [SAMPLE_WIDTH-1:0] first_left_re,
  input  logic signed [SAMPLE_WIDTH-1:0] first_left_im,
  input  logic signed [SAMPLE_WIDTH-1:0] first_right_re,
  input  logic signed [SAMPLE_WIDTH-1:0] first_right_im,
  input  logic signed [SAMPLE_WIDTH-1:0] second_left_re,
  input  logic signed [SAMPLE_WIDTH-1:0] second_left_im,
  input  logic signed [SAMPLE_WIDTH-1:0] second_right_re,
  input  logic signed [SAMPLE_WIDTH-1:0] second_right_im,
  input  logic                          last_item,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [ACC_WIDTH-1:0]   plain_re,
  output logic signed [ACC_WIDTH-1:0]   plain_im,
  output logic signed [ACC_WIDTH-1:0]   gamma_re,
  output logic signed [ACC_WIDTH-1:0]   gamma_im,
  output logic                          saturated
);
  import gsip_pkg::*;

  localparam int PW = 2 * SAMPLE_WIDTH;
  localparam int CW = PW + 2;

  dir_t                         mu;
  tag_t                         tag1;
  tag_t                         tag2;
  tag_t                         tag3;
  logic                         sel1;
  logic                         sel2;
  logic signed [SAMPLE_WIDTH-1:0] flr, fli, frr, fri, slr, sli, srr, sri;
  logic signed [PW-1:0]         prod [4][4];
  logic signed [CW-1:0]         contrib [4];
  logic signed [ACC_WIDTH-1:0]  sum_next [4];
  logic                         clip_next;
  logic                         acc_take;
  logic                         acc_capture;
  logic                         fin_en;
  logic                         en1;
  logic                         en2;
  logic                         en3;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mu <= '0;
    end else if (cfg_valid) begin
      mu <= direction;
    end
  end

  assign en3      = !tag3.valid || acc_take;
  assign en2      = !tag2.valid || en3;
  assign en1      = !tag1.valid || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag1 <= '0;
    end else if (en1) begin
      tag1 <= '{valid: in_valid, last: last_item};
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      sel1 <= pair_select;
      flr  <= first_left_re;
      fli  <= first_left_im;
      frr  <= first_right_re;
      fri  <= first_right_im;
      slr  <= second_left_re;
      sli  <= second_left_im;
      srr  <= second_right_re;
      sri  <= second_right_im;
    end
  end

  gsip_mult #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_mult (
    .clk     (clk),
    .rst     (rst),
    .en      (en2),
    .tag_in  (tag1),
    .sel_in  (sel1),
    .flr     (flr),
    .fli     (fli),
    .frr     (frr),
    .fri     (fri),
    .slr     (slr),
    .sli     (sli),
    .srr     (srr),
    .sri     (sri),
    .tag_out (tag2),
    .sel_out (sel2),
    .prod    (prod)
  );

  gsip_combine #(.SAMPLE_WIDTH(SAMPLE_WIDTH)) u_combine (
    .clk     (clk),
    .rst     (rst),
    .en      (en3),
    .mu      (mu),
    .tag_in  (tag2),
    .sel_in  (sel2),
    .prod    (prod),
    .tag_out (tag3),
    .contrib (contrib)
  );

  gsip_accum #(.SAMPLE_WIDTH(SAMPLE_WIDTH), .ACC_WIDTH(ACC_WIDTH)) u_accum (
    .clk       (clk),
    .rst       (rst),
    .tag_in    (tag3),
    .contrib   (contrib),
    .fin_en    (fin_en),
    .take      (acc_take),
    .capture   (acc_capture),
    .sum_next  (sum_next),
    .clip_next (clip_next)
  );

  gsip_finish #(.ACC_WIDTH(ACC_WIDTH)) u_finish (
    .clk       (clk),
    .rst       (rst),
    .capture   (acc_capture),
    .sum_in    (sum_next),
    .clip_in   (clip_next),
    .dir_odd   (mu[0]),
    .out_ready (out_ready),
    .fin_en    (fin_en),
    .out_valid (out_valid),
    .plain_re  (plain_re),
    .plain_im  (plain_im),
    .gamma_re  (gamma_re),
    .gamma_im  (gamma_im),
    .saturated (saturated)
  );

  a_capture_room: assert property (@(posedge clk) disable iff (rst)
    acc_capture |-> fin_en)
    else $error("final sums captured while result stage is full");

  a_mid_no_stall: assert property (@(posedge clk) disable iff (rst)
    (tag3.valid && !tag3.last) |-> acc_take)
    else $error("non-final request stalled at the accumulators");

  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> tag1.valid)
    else $error("input held off with an empty input stage");

endmodule

// ===== hdl/gsip_mult.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsip_mult: product stage
// Sixteen registered sample products, grouped by accumulator and term.
// ----------------------------------------------------------------------------
module gsip_mult #(
  parameter int SAMPLE_WIDTH = 16,
  localparam int PW = 2 * SAMPLE_WIDTH
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  gsip_pkg::tag_t                tag_in,
  input  logic                          sel_in,
  input  logic signed [SAMPLE_WIDTH-1:0] flr,
  input  logic signed [SAMPLE_WIDTH-1:0] fli,
  input  logic signed [SAMPLE_WIDTH-1:0] frr,
  input  logic signed [SAMPLE_WIDTH-1:0] fri,
  input  logic signed [SAMPLE_WIDTH-1:0] slr,
  input  logic signed [SAMPLE_WIDTH-1:0] sli,
  input  logic signed [SAMPLE_WIDTH-1:0] srr,
  input  logic signed [SAMPLE_WIDTH-1:0] sri,
  output gsip_pkg::tag_t                tag_out,
  output logic                          sel_out,
  output logic signed [PW-1:0]          prod [4][4]
);
  import gsip_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (en) begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sel_out <= sel_in;
      prod[SUM_PLAIN_RE][0] <= flr * frr;
      prod[SUM_PLAIN_RE][1] <= fli * fri;
      prod[SUM_PLAIN_RE][2] <= slr * srr;
      prod[SUM_PLAIN_RE][3] <= sli * sri;
      prod[SUM_PLAIN_IM][0] <= flr * fri;
      prod[SUM_PLAIN_IM][1] <= fli * frr;
      prod[SUM_PLAIN_IM][2] <= slr * sri;
      prod[SUM_PLAIN_IM][3] <= sli * srr;
      prod[SUM_CROSS_RE][0] <= flr * srr;
      prod[SUM_CROSS_RE][1] <= fli * sri;
      prod[SUM_CROSS_RE][2] <= slr * frr;
      prod[SUM_CROSS_RE][3] <= sli * fri;
      prod[SUM_CROSS_IM][0] <= flr * sri;
      prod[SUM_CROSS_IM][1] <= fli * srr;
      prod[SUM_CROSS_IM][2] <= slr * fri;
      prod[SUM_CROSS_IM][3] <= sli * frr;
    end
  end

endmodule

// ===== hdl/gsip_combine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsip_combine: contribution stage
// Applies conjugate and gamma signs, sums four terms per accumulator.
// ----------------------------------------------------------------------------
module gsip_combine #(
  parameter int SAMPLE_WIDTH = 16,
  localparam int PW = 2 * SAMPLE_WIDTH,
  localparam int CW = PW + 2
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  gsip_pkg::dir_t        mu,
  input  gsip_pkg::tag_t        tag_in,
  input  logic                  sel_in,
  input  logic signed [PW-1:0]  prod [4][4],
  output gsip_pkg::tag_t        tag_out,
  output logic signed [CW-1:0]  contrib [4]
);
  import gsip_pkg::*;

  logic [1:0]           sp;
  logic [3:0]           neg [4];
  logic signed [CW-1:0] term [4][4];
  logic signed [CW-1:0] total [4];

  always_comb begin
    sp = sign_pair(mu, sel_in);
    neg[SUM_PLAIN_RE] = 4'b0000;
    neg[SUM_PLAIN_IM] = 4'b1010;
    neg[SUM_CROSS_RE] = {sp[SIGN_B], sp[SIGN_B], sp[SIGN_A], sp[SIGN_A]};
    neg[SUM_CROSS_IM] = {~sp[SIGN_B], sp[SIGN_B], ~sp[SIGN_A], sp[SIGN_A]};
    for (int s = 0; s < NUM_SUMS; s++) begin
      for (int k = 0; k < 4; k++) begin
        term[s][k] = neg[s][k] ? -CW'(prod[s][k]) : CW'(prod[s][k]);
      end
      total[s] = term[s][0] + term[s][1] + term[s][2] + term[s][3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag_out <= '0;
    end else if (en) begin
      tag_out <= tag_in;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      contrib <= total;
    end
  end

endmodule

// ===== hdl/gsip_accum.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsip_accum: saturating accumulators
// Four saturating sums and the clip flag; clear after the last request.
// ----------------------------------------------------------------------------
module gsip_accum #(
  parameter int SAMPLE_WIDTH = 16,
  parameter int ACC_WIDTH = 52,
  localparam int CW = 2 * SAMPLE_WIDTH + 2,
  localparam int SW = ((ACC_WIDTH > CW) ? ACC_WIDTH : CW) + 1
) (
  input  logic                        clk,
  input  logic                        rst,
  input  gsip_pkg::tag_t              tag_in,
  input  logic signed [CW-1:0]        contrib [4],
  input  logic                        fin_en,
  output logic                        take,
  output logic                        capture,
  output logic signed [ACC_WIDTH-1:0] sum_next [4],
  output logic                        clip_next
);
  import gsip_pkg::*;

  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic signed [ACC_WIDTH-1:0]  sums [4];
  logic                         clip;
  logic signed [SW-1:0]         wide [4];
  logic [SW-ACC_WIDTH:0]        high [4];
  logic [3:0]                   over;

  always_comb begin
    take    = tag_in.valid && (!tag_in.last || fin_en);
    capture = take && tag_in.last;
    for (int s = 0; s < NUM_SUMS; s++) begin
      wide[s] = SW'(sums[s]) + SW'(contrib[s]);
      high[s] = wide[s][SW-1:ACC_WIDTH-1];
      over[s] = !((high[s] == '0) || (high[s] == '1));
      if (!over[s]) begin
        sum_next[s] = wide[s][ACC_WIDTH-1:0];
      end else if (wide[s][SW-1]) begin
        sum_next[s] = ACC_MIN;
      end else begin
        sum_next[s] = ACC_MAX;
      end
    end
    clip_next = clip || (over != '0);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < NUM_SUMS; s++) begin
        sums[s] <= '0;
      end
      clip <= 1'b0;
    end else if (take) begin
      if (tag_in.last) begin
        for (int s = 0; s < NUM_SUMS; s++) begin
          sums[s] <= '0;
        end
        clip <= 1'b0;
      end else begin
        sums <= sum_next;
        clip <= clip_next;
      end
    end
  end

endmodule

// ===== hdl/gsip_finish.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsip_finish: result stage
// Holds the final sums, applies the gamma negate or times minus i, and
// drives the result register.
// ----------------------------------------------------------------------------
module gsip_finish #(
  parameter int ACC_WIDTH = 52
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        capture,
  input  logic signed [ACC_WIDTH-1:0] sum_in [4],
  input  logic                        clip_in,
  input  logic                        dir_odd,
  input  logic                        out_ready,
  output logic                        fin_en,
  output logic                        out_valid,
  output logic signed [ACC_WIDTH-1:0] plain_re,
  output logic signed [ACC_WIDTH-1:0] plain_im,
  output logic signed [ACC_WIDTH-1:0] gamma_re,
  output logic signed [ACC_WIDTH-1:0] gamma_im,
  output logic                        saturated
);
  import gsip_pkg::*;

  localparam logic [ACC_WIDTH-1:0] ACC_MAX = {1'b0, {(ACC_WIDTH-1){1'b1}}};
  localparam logic [ACC_WIDTH-1:0] ACC_MIN = {1'b1, {(ACC_WIDTH-1){1'b0}}};

  logic                        held;
  logic signed [ACC_WIDTH-1:0] hold_sum [4];
  logic                        hold_clip;
  logic                        hold_odd;
  logic                        en_out;
  logic                        re_min;
  logic                        im_min;
  logic signed [ACC_WIDTH-1:0] neg_re;
  logic signed [ACC_WIDTH-1:0] neg_im;
  logic signed [ACC_WIDTH-1:0] gamma_re_next;
  logic signed [ACC_WIDTH-1:0] gamma_im_next;
  logic                        saturated_next;

  always_comb begin
    en_out = !out_valid || out_ready;
    fin_en = !held || en_out;
    re_min = hold_sum[SUM_CROSS_RE] == ACC_MIN;
    im_min = hold_sum[SUM_CROSS_IM] == ACC_MIN;
    neg_re = re_min ? ACC_MAX : -hold_sum[SUM_CROSS_RE];
    neg_im = im_min ? ACC_MAX : -hold_sum[SUM_CROSS_IM];
    if (hold_odd) begin
      gamma_re_next  = hold_sum[SUM_CROSS_IM];
      gamma_im_next  = neg_re;
      saturated_next = hold_clip || re_min;
    end else begin
      gamma_re_next  = neg_re;
      gamma_im_next  = neg_im;
      saturated_next = hold_clip || re_min || im_min;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held      <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (fin_en) begin
        held <= capture;
      end
      if (en_out) begin
        out_valid <= held;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (capture) begin
      hold_sum  <= sum_in;
      hold_clip <= clip_in;
      hold_odd  <= dir_odd;
    end
    if (en_out && held) begin
      plain_re  <= hold_sum[SUM_PLAIN_RE];
      plain_im  <= hold_sum[SUM_PLAIN_IM];
      gamma_re  <= gamma_re_next;
      gamma_im  <= gamma_im_next;
      saturated <= saturated_next;
    end
  end

endmodule
